### sv/ptss_pkg.sv
package ptss_pkg;

   localparam int unsigned MAX_POINTS_DEFAULT = 64;

   localparam int unsigned Q_W        = 32;  // signed Q16.16 word
   localparam int unsigned T_W        = 32;  // unsigned Q16.16 time
   localparam int unsigned STEP_W     = 31;  // time_step register
   localparam int unsigned MAX_PTS_W  = 7;   // max_points register
   localparam int unsigned HALF_W     = 47;  // t*t >> 17
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   typedef logic signed [Q_W-1:0] q16_type;
   typedef q16_type [2:0] vec3_type;

   typedef struct packed {
      vec3_type vel;
      vec3_type pos;
   } launch_type;

   typedef struct packed {
      vec3_type vel;
      vec3_type pos;
   } point_type;

   typedef struct packed {
      vec3_type              gravity;
      q16_type               ground_height;
      logic [STEP_W-1:0]     time_step;
      logic [MAX_PTS_W-1:0]  max_points;
   } cfg_type;

   typedef enum logic [2:0] {
      REG_GRAVITY_X     = 3'd0,
      REG_GRAVITY_Y     = 3'd1,
      REG_GRAVITY_Z     = 3'd2,
      REG_GROUND_HEIGHT = 3'd3,
      REG_TIME_STEP     = 3'd4,
      REG_MAX_POINTS    = 3'd5
   } reg_index_type;

   localparam q16_type              GRAVITY_X_RESET  = q16_type'(0);
   localparam q16_type              GRAVITY_Y_RESET  = q16_type'(-642908);
   localparam q16_type              GRAVITY_Z_RESET  = q16_type'(0);
   localparam q16_type              GROUND_RESET     = q16_type'(0);
   localparam logic [STEP_W-1:0]    TIME_STEP_RESET  = STEP_W'(6554);
   localparam logic [MAX_PTS_W-1:0] MAX_POINTS_RESET = MAX_PTS_W'(64);

   localparam int unsigned REQ_W = $bits(launch_type);
   localparam int unsigned RSP_W = $bits(point_type) + T_W;

endpackage

### sv/ptss_mul.sv
// Shared 33x33 signed multiplier, product registered.
module ptss_mul import ptss_pkg::*; (
   input  logic                clock,
   input  logic signed [32:0]  mul_a,
   input  logic [31:0]         mul_b,
   output logic signed [64:0]  product
);

   logic signed [65:0] product_in;
   logic signed [64:0] product_ff;

   assign product_in = mul_a * $signed({1'b0, mul_b});

   always_ff @(posedge clock) begin
      product_ff <= product_in[64:0];
   end

   assign product = product_ff;

endmodule

### sv/ptss_csr.sv
// Configuration registers behind the APB-style port.
module ptss_csr import ptss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output cfg_type               cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_idx;
   logic          wr_en;

   assign reg_idx = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en   = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_GRAVITY_X:     cfg_in.gravity[0]    = q16_type'(csr_pwdata);
            REG_GRAVITY_Y:     cfg_in.gravity[1]    = q16_type'(csr_pwdata);
            REG_GRAVITY_Z:     cfg_in.gravity[2]    = q16_type'(csr_pwdata);
            REG_GROUND_HEIGHT: cfg_in.ground_height = q16_type'(csr_pwdata);
            REG_TIME_STEP:     cfg_in.time_step     = csr_pwdata[STEP_W-1:0];
            REG_MAX_POINTS:    cfg_in.max_points    = csr_pwdata[MAX_PTS_W-1:0];
            default:           cfg_in = cfg_ff;  // unmapped: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gravity[0]    <= GRAVITY_X_RESET;
         cfg_ff.gravity[1]    <= GRAVITY_Y_RESET;
         cfg_ff.gravity[2]    <= GRAVITY_Z_RESET;
         cfg_ff.ground_height <= GROUND_RESET;
         cfg_ff.time_step     <= TIME_STEP_RESET;
         cfg_ff.max_points    <= MAX_POINTS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_GRAVITY_X:     csr_prdata = cfg_ff.gravity[0];
         REG_GRAVITY_Y:     csr_prdata = cfg_ff.gravity[1];
         REG_GRAVITY_Z:     csr_prdata = cfg_ff.gravity[2];
         REG_GROUND_HEIGHT: csr_prdata = cfg_ff.ground_height;
         REG_TIME_STEP:     csr_prdata = CSR_DATA_W'(cfg_ff.time_step);
         REG_MAX_POINTS:    csr_prdata = CSR_DATA_W'(cfg_ff.max_points);
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### sv/ptss_engine.sv
// One trajectory point: 13 products through the shared multiplier.
// Op order: t*t, then per axis v*t, g*t, g*half_hi, g*half_lo.
// Axis operands rotate after each axis so the current one sits in [0].
module ptss_engine import ptss_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  launch_type     launch,
   input  vec3_type       gravity,
   input  logic           start,
   input  logic [T_W-1:0] t_value,
   output logic           done,
   output point_type      result
);

   typedef enum logic [4:0] {
      OP_TT  = 5'b00001,
      OP_VT  = 5'b00010,
      OP_GT  = 5'b00100,
      OP_GHH = 5'b01000,
      OP_GHL = 5'b10000
   } op_type;

   localparam int unsigned PACC_W = 50;
   localparam int unsigned WACC_W = 66;
   localparam logic [3:0]  LAST_STEP = 4'd12;

   logic        busy_ff, busy_in;
   logic [3:0]  step_ff, step_in;
   logic [3:0]  step_m1;
   logic        fin_ff, fin_in;
   logic        done_ff;
   logic        cval_ff;
   op_type      cop_ff;
   op_type      iop;

   vec3_type    pos0_ff, vel0_ff, grav_ff;
   vec3_type    res_pos_ff, res_vel_ff;
   logic [HALF_W-1:0]        half_ff;
   logic signed [PACC_W-1:0] pacc_ff;
   logic signed [WACC_W-1:0] wacc_ff;

   logic signed [32:0]       mul_a;
   logic [31:0]              mul_b;
   logic signed [64:0]       mul_p;
   logic signed [48:0]       p_shr;
   logic signed [PACC_W-1:0] vt_sum, gt_sum;
   logic signed [WACC_W-1:0] ghh_sum, ghl_sum;
   q16_type                  gt_sat, ghl_sat;

   function automatic q16_type sat32(input logic signed [WACC_W-1:0] v);
      logic in_range;
      in_range = (v[WACC_W-1:31] == '0) || (v[WACC_W-1:31] == '1);
      if (in_range) begin
         return v[31:0];
      end else if (v[WACC_W-1]) begin
         return {1'b1, 31'b0};
      end else begin
         return {1'b0, {31{1'b1}}};
      end
   endfunction

   // issue side
   assign step_m1 = step_ff - 4'd1;

   always_comb begin
      iop = OP_TT;
      if (step_ff != '0) begin
         case (step_m1[1:0])
            2'd0:    iop = OP_VT;
            2'd1:    iop = OP_GT;
            2'd2:    iop = OP_GHH;
            2'd3:    iop = OP_GHL;
            default: iop = OP_TT;
         endcase
      end
   end

   always_comb begin
      case (iop)
         OP_VT: begin
            mul_a = {vel0_ff[0][Q_W-1], vel0_ff[0]};
            mul_b = t_value;
         end
         OP_GT: begin
            mul_a = {grav_ff[0][Q_W-1], grav_ff[0]};
            mul_b = t_value;
         end
         OP_GHH: begin
            mul_a = {grav_ff[0][Q_W-1], grav_ff[0]};
            mul_b = 32'(half_ff[HALF_W-1:32]);
         end
         OP_GHL: begin
            mul_a = {grav_ff[0][Q_W-1], grav_ff[0]};
            mul_b = half_ff[31:0];
         end
         default: begin
            mul_a = {1'b0, t_value};
            mul_b = t_value;
         end
      endcase
   end

   ptss_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (mul_p)
   );

   // consume side: product >>> 16 is floor division
   assign p_shr   = mul_p[64:16];
   assign vt_sum  = {{18{pos0_ff[0][Q_W-1]}}, pos0_ff[0]} + {p_shr[48], p_shr};
   assign gt_sum  = {{18{vel0_ff[0][Q_W-1]}}, vel0_ff[0]} + {p_shr[48], p_shr};
   assign gt_sat  = sat32({{16{gt_sum[PACC_W-1]}}, gt_sum});
   // floor((hi*2^32 + lo)/2^16) + acc = (hi*2^16 + acc) + floor(lo/2^16)
   assign ghh_sum = {mul_p[49:0], 16'b0} + {{16{pacc_ff[PACC_W-1]}}, pacc_ff};
   assign ghl_sum = wacc_ff + {{17{p_shr[48]}}, p_shr};
   assign ghl_sat = sat32(ghl_sum);

   // sequencer
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      fin_in  = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cval_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         fin_ff  <= fin_in;
         done_ff <= fin_ff;
         cval_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      cop_ff <= iop;
      if (load) begin
         pos0_ff <= launch.pos;
         vel0_ff <= launch.vel;
         grav_ff <= gravity;
      end else if (busy_ff && (iop == OP_GHL)) begin
         pos0_ff <= {pos0_ff[0], pos0_ff[2:1]};
         vel0_ff <= {vel0_ff[0], vel0_ff[2:1]};
         grav_ff <= {grav_ff[0], grav_ff[2:1]};
      end
      if (cval_ff) begin
         case (cop_ff)
            OP_TT:   half_ff    <= mul_p[63:17];
            OP_VT:   pacc_ff    <= vt_sum;
            OP_GT:   res_vel_ff <= {gt_sat, res_vel_ff[2:1]};
            OP_GHH:  wacc_ff    <= ghh_sum;
            OP_GHL:  res_pos_ff <= {ghl_sat, res_pos_ff[2:1]};
            default: half_ff    <= half_ff;
         endcase
      end
   end

   assign done       = done_ff;
   assign result.pos = res_pos_ff;
   assign result.vel = res_vel_ff;

endmodule

### sv/projectile_trajectory_sampler_unit.sv
// Each point takes 13 products through one shared 33x33 multiplier, one point at a time;
//   a launch holds the input side until its last point is loaded into the output register.
// Reset (synchronous, active high): registers to documented values, block idle, no output.
module projectile_trajectory_sampler_unit import ptss_pkg::*; #(
   parameter int unsigned MAX_POINTS_LIMIT = MAX_POINTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // launch input
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // req_tdata, low to high: launch_pos_x, launch_pos_y, launch_pos_z,
   //   launch_vel_x, launch_vel_y, launch_vel_z (32 bits each)
   input  logic [REQ_W-1:0]      req_tdata,
   // trajectory points
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata, low to high: position_x, position_y, position_z,
   //   velocity_x, velocity_y, velocity_z, sample_time (32 bits each)
   output logic [RSP_W-1:0]      rsp_tdata,
   output logic                  rsp_tlast,      // last_point
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // point counter holds 0..MAX_POINTS_LIMIT
   localparam int unsigned CNT_W  = $clog2(MAX_POINTS_LIMIT + 1);
   // exact i*time_step, i < MAX_POINTS_LIMIT
   localparam int unsigned TACC_W = T_W + 1 + $clog2(MAX_POINTS_LIMIT);
   localparam logic [MAX_PTS_W-1:0] MAX_LIM = MAX_PTS_W'(MAX_POINTS_LIMIT);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,   // waiting for a launch
      ST_CALC  = 4'b0010,   // engine computing a point
      ST_EMIT  = 4'b0100,   // next point known: send the held one
      ST_FLUSH = 4'b1000    // send the held point as the last one
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   idx_ff, idx_in, idx_inc;
   logic [CNT_W-1:0]   limit_ff, limit_in, eff_limit;
   logic [TACC_W-1:0]  tacc_ff, tacc_in, tacc_step;
   logic [T_W-1:0]     t_sat;

   // point held back until we know whether another one follows
   point_type          pend_ff;
   logic [T_W-1:0]     pend_time_ff;
   logic               pend_load;

   // output register
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   point_type          rsp_pt_ff;
   logic [T_W-1:0]     rsp_time_ff;
   logic               rsp_last_ff;
   logic               out_load, out_last, out_free;

   logic               req_accept;
   logic               eng_load, eng_start, eng_done;
   point_type          eng_result;
   logic               below_ground;
   cfg_type            cfg;

   ptss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   assign csr_pready = 1'b1;

   ptss_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .load    (eng_load),
      .launch  (launch_type'(req_tdata)),
      .gravity (cfg.gravity),
      .start   (eng_start),
      .t_value (t_sat),
      .done    (eng_done),
      .result  (eng_result)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign out_free   = ~rsp_tvalid_ff | rsp_tready;

   // sample time saturates at all ones; tacc itself stays exact
   assign t_sat     = (tacc_ff[TACC_W-1:T_W] != '0) ? '1 : tacc_ff[T_W-1:0];
   assign tacc_step = tacc_ff + TACC_W'(cfg.time_step);
   assign idx_inc   = idx_ff + CNT_W'(1);

   assign below_ground = $signed(eng_result.pos[1]) < $signed(cfg.ground_height);

   // limit of zero still gives the first point; clamp at the build limit
   always_comb begin
      if (cfg.max_points == '0) begin
         eff_limit = CNT_W'(1);
      end else if (cfg.max_points > MAX_LIM) begin
         eff_limit = CNT_W'(MAX_POINTS_LIMIT);
      end else begin
         eff_limit = CNT_W'(cfg.max_points);
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      limit_in  = limit_ff;
      tacc_in   = tacc_ff;
      eng_load  = 1'b0;
      eng_start = 1'b0;
      pend_load = 1'b0;
      out_load  = 1'b0;
      out_last  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               eng_load  = 1'b1;
               eng_start = 1'b1;
               idx_in    = '0;
               tacc_in   = '0;
               limit_in  = eff_limit;
               state_in  = ST_CALC;
            end
         end
         ST_CALC: begin
            if (eng_done) begin
               if (idx_ff == '0) begin
                  // first point is never ground-tested
                  pend_load = 1'b1;
                  if (limit_ff == CNT_W'(1)) begin
                     state_in = ST_FLUSH;
                  end else begin
                     idx_in    = idx_inc;
                     tacc_in   = tacc_step;
                     eng_start = 1'b1;
                  end
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_last = below_ground;
               if (below_ground) begin
                  // new point is dropped, held one closes the launch
                  state_in = ST_IDLE;
               end else begin
                  pend_load = 1'b1;
                  if (idx_inc == limit_ff) begin
                     state_in = ST_FLUSH;
                  end else begin
                     idx_in    = idx_inc;
                     tacc_in   = tacc_step;
                     eng_start = 1'b1;
                     state_in  = ST_CALC;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_load = 1'b1;
               out_last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         limit_ff      <= CNT_W'(1);
         tacc_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         limit_ff      <= limit_in;
         tacc_ff       <= tacc_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload: output takes the held point before the held point is replaced
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pt_ff   <= pend_ff;
         rsp_time_ff <= pend_time_ff;
         rsp_last_ff <= out_last;
      end
      if (pend_load) begin
         pend_ff      <= eng_result;
         pend_time_ff <= t_sat;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_time_ff, rsp_pt_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

### sv/ptss_checker.sv
module ptss_checker import ptss_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_W-1:0]      req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_W-1:0]      rsp_tdata,
   input logic                  rsp_tlast,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   input logic [CSR_DATA_W-1:0] csr_prdata,
   input logic                  csr_pready
);

   // reset leaves the block idle with nothing to send
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("not idle after reset");

   // a launch keeps the block busy, so it is not ready again straight away
   a_busy_after_launch: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready ##1 !req_tready ##1 !req_tready)
      else $error("ready again too soon after a launch transfer");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("result changed while stalled");

   // gravity_x reads back what was written
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == '0) |=>
         (csr_paddr != '0 || csr_prdata == $past(csr_pwdata)))
      else $error("gravity_x readback mismatch");

endmodule

bind projectile_trajectory_sampler_unit ptss_checker u_ptss_checker (.*);

### verif/trajectory_checker.sv
`timescale 1ns / 1ps
module trajectory_checker import ptss_pkg::*; #(
   parameter int unsigned MAX_POINTS_LIMIT = MAX_POINTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // req_tdata, low to high: launch_pos_x/y/z, launch_vel_x/y/z
   input  logic [REQ_W-1:0]      req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata, low to high: position_x/y/z, velocity_x/y/z, sample_time
   input  logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int unsigned           mismatch_count,
   output int unsigned           points_outstanding
);

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic           last_point;
      logic [T_W-1:0] sample_time;
      point_type      point;
   } point_record_type;

   localparam int unsigned FIELD_COUNT = 7;
   localparam wide_type TERM_LIMIT = 128'sh2000_0000_0000_0000;
   localparam wide_type Q_MAX      = 128'sh7FFF_FFFF;
   localparam wide_type Q_MIN      = -128'sh8000_0000;

   string field_names [FIELD_COUNT] = '{"position_x", "position_y", "position_z",
                                        "velocity_x", "velocity_y", "velocity_z",
                                        "sample_time"};

   cfg_type          settings;
   point_record_type expected_points [$];

   // floor(a*b / 2^16), clamped to +-2^61
   function automatic wide_type scaled_product(input wide_type a, input wide_type b);
      wide_type q;
      q = (a * b) >>> 16;
      if (q > TERM_LIMIT) begin
         q = TERM_LIMIT;
      end else if (q < -TERM_LIMIT) begin
         q = -TERM_LIMIT;
      end
      return q;
   endfunction

   function automatic q16_type saturate_q16(input wide_type v);
      wide_type clamped;
      clamped = (v > Q_MAX) ? Q_MAX : ((v < Q_MIN) ? Q_MIN : v);
      return clamped[Q_W-1:0];
   endfunction

   function automatic logic [T_W-1:0] sample_time_at(input int unsigned index);
      logic [39:0] t_full;
      t_full = 40'(index) * 40'(settings.time_step);
      return (t_full > 40'hFFFF_FFFF) ? '1 : t_full[T_W-1:0];
   endfunction

   // one record per point; the last flag needs the next point's ground test
   function automatic void predict_trajectory(input launch_type launch);
      int unsigned      limit;
      int unsigned      index;
      logic [T_W-1:0]   t;
      logic [2*T_W-1:0] t_squared;
      wide_type         t_wide;
      wide_type         half_wide;
      point_record_type held;
      point_record_type current;
      logic             done;
      limit = settings.max_points;
      if (limit < 1) begin
         limit = 1;
      end
      if (limit > MAX_POINTS_LIMIT) begin
         limit = MAX_POINTS_LIMIT;
      end
      done  = 1'b0;
      index = 0;
      held  = '0;
      while (!done && index < limit) begin
         t         = sample_time_at(index);
         t_squared = {32'd0, t} * {32'd0, t};
         t_wide    = $signed({96'd0, t});
         half_wide = $signed({81'd0, t_squared[2*T_W-1:17]});
         for (int k = 0; k < 3; k++) begin
            current.point.pos[k] = saturate_q16($signed(launch.pos[k])
               + scaled_product($signed(launch.vel[k]), t_wide)
               + scaled_product($signed(settings.gravity[k]), half_wide));
            current.point.vel[k] = saturate_q16($signed(launch.vel[k])
               + scaled_product($signed(settings.gravity[k]), t_wide));
         end
         current.sample_time = t;
         current.last_point  = 1'b0;
         if (index > 0 && $signed(current.point.pos[1]) < $signed(settings.ground_height)) begin
            done = 1'b1;
         end else begin
            if (index > 0) begin
               expected_points.push_back(held);
            end
            held  = current;
            index = index + 1;
         end
      end
      held.last_point = 1'b1;
      expected_points.push_back(held);
   endfunction

   always @(posedge clock) begin : monitor
      point_record_type expected;
      logic [RSP_W-1:0] expected_word;
      if (reset) begin
         settings.gravity[0]    = GRAVITY_X_RESET;
         settings.gravity[1]    = GRAVITY_Y_RESET;
         settings.gravity[2]    = GRAVITY_Z_RESET;
         settings.ground_height = GROUND_RESET;
         settings.time_step     = TIME_STEP_RESET;
         settings.max_points    = MAX_POINTS_RESET;
         expected_points.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               $error("point transfer with none expected: tdata 0x%h", rsp_tdata);
               mismatch_count++;
            end else begin
               expected      = expected_points.pop_front();
               expected_word = {expected.sample_time, expected.point};
               for (int f = 0; f < FIELD_COUNT; f++) begin
                  if (rsp_tdata[f*32 +: 32] !== expected_word[f*32 +: 32]) begin
                     $error("%s: expected 0x%08h, got 0x%08h", field_names[f],
                            expected_word[f*32 +: 32], rsp_tdata[f*32 +: 32]);
                     mismatch_count++;
                  end
               end
               if (rsp_tlast !== expected.last_point) begin
                  $error("last_point: expected %0d, got %0d", expected.last_point, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_trajectory(launch_type'(req_tdata));
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
               REG_GRAVITY_X:     settings.gravity[0]    = csr_pwdata;
               REG_GRAVITY_Y:     settings.gravity[1]    = csr_pwdata;
               REG_GRAVITY_Z:     settings.gravity[2]    = csr_pwdata;
               REG_GROUND_HEIGHT: settings.ground_height = csr_pwdata;
               REG_TIME_STEP:     settings.time_step     = csr_pwdata[STEP_W-1:0];
               REG_MAX_POINTS:    settings.max_points    = csr_pwdata[MAX_PTS_W-1:0];
               default: ;
            endcase
         end
      end
      points_outstanding = expected_points.size();
   end

endmodule

### verif/tb_projectile_trajectory_sampler_unit.sv
`timescale 1ns / 1ps
module tb_projectile_trajectory_sampler_unit;
   import ptss_pkg::*;

   localparam int unsigned HALF_PERIOD     = 10;
   localparam int unsigned RESET_CYCLES    = 12;
   localparam int unsigned MAX_GAP         = 6;
   // allow a margin before touching registers
   localparam int unsigned SETTLE_CYCLES   = 40;
   // longest legal silence is two point computations plus a stall, or the settle wait
   localparam int unsigned QUIET_LIMIT     = 5000;
   localparam int unsigned RANDOM_PHASES   = 6;
   localparam int unsigned ITEMS_PER_PHASE = 25;
   localparam logic [2:0]  UNMAPPED_REG    = 3'd6;

   localparam q16_type Q_MAX = 32'h7FFF_FFFF;
   localparam q16_type Q_MIN = 32'h8000_0000;
   localparam q16_type ONE   = 32'h0001_0000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // req_tdata, low to high: launch_pos_x/y/z, launch_vel_x/y/z
   logic [REQ_W-1:0]      req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // rsp_tdata, low to high: position_x/y/z, velocity_x/y/z, sample_time
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int unsigned mismatch_count;
   int unsigned points_outstanding;
   int unsigned quiet_cycles = 0;

   // when set, neither side inserts idle cycles
   bit      steady = 1'b0;
   // ground level currently programmed; shapes launches that actually fly
   q16_type active_ground;

   always #(HALF_PERIOD) clock = ~clock;

   projectile_trajectory_sampler_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   trajectory_checker trajectory_check (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .rsp_tlast          (rsp_tlast),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_pready         (csr_pready),
      .mismatch_count     (mismatch_count),
      .points_outstanding (points_outstanding)
   );

   // Watchdog: any transfer on any port restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("tb_projectile_trajectory_sampler_unit NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Point sink: random stall before each transfer, ready held until the point arrives.
   initial begin : point_sink
      int unsigned stall;
      rsp_tready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // APB write: setup cycle, then access cycle; returns at a falling edge.
   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Raw 32-bit words go out so the unused upper bits of narrow registers toggle too.
   task automatic configure(input logic [31:0] gx, input logic [31:0] gy,
                            input logic [31:0] gz, input logic [31:0] ground,
                            input logic [31:0] step, input logic [31:0] points);
      write_reg(REG_GRAVITY_X, gx);
      write_reg(REG_GRAVITY_Y, gy);
      write_reg(REG_GRAVITY_Z, gz);
      write_reg(REG_GROUND_HEIGHT, ground);
      write_reg(REG_TIME_STEP, step);
      write_reg(REG_MAX_POINTS, points);
      active_ground = ground;
   endtask

   // Stop feeding, let every predicted point come back, then give the engine time to settle.
   task automatic wait_for_idle;
      req_tvalid = 1'b0;
      while (points_outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Launch source: valid stays high across back-to-back transfers (gap of zero).
   task automatic send_launch(input launch_type launch);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = launch;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic launch_type make_launch(input q16_type px, input q16_type py,
                                              input q16_type pz, input q16_type vx,
                                              input q16_type vy, input q16_type vz);
      launch_type launch;
      launch.pos[0] = px;
      launch.pos[1] = py;
      launch.pos[2] = pz;
      launch.vel[0] = vx;
      launch.vel[1] = vy;
      launch.vel[2] = vz;
      return launch;
   endfunction

   // uniform in [-span, span]
   function automatic q16_type spread(input int unsigned span);
      return q16_type'($urandom_range(0, 2 * span)) - q16_type'(span);
   endfunction

   // Shaped launches start above ground with an upward velocity, so they fly for a
   // while and end on the ground test; the rest are raw noise over all bits.
   function automatic launch_type random_launch(input bit shaped);
      launch_type launch;
      if (!shaped) begin
         launch = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
         launch.pos[0] = $urandom_range(0, 3) == 0 ? q16_type'($urandom) : spread(1000 << 16);
         launch.pos[1] = active_ground + q16_type'($urandom_range(0, 200 << 16));
         launch.pos[2] = spread(1000 << 16);
         launch.vel[0] = spread(20 << 16);
         launch.vel[1] = q16_type'($urandom_range(0, 40 << 16));
         launch.vel[2] = spread(20 << 16);
      end
      return launch;
   endfunction

   // Mostly earth-like gravity and short steps; one phase with long point limits
   // (including values past the cap), one with every register fully random.
   task automatic random_settings(input int unsigned phase);
      if (phase == 3) begin
         configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
         configure(spread(2 << 16), -q16_type'($urandom_range(1 << 16, 30 << 16)),
                   spread(2 << 16), spread(1000 << 16), $urandom_range(1000, 20000),
                   (phase == 1) ? $urandom_range(17, 127) : $urandom_range(0, 16));
      end
   endtask

   initial begin : stimulus
      int unsigned phase;
      int unsigned item;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      active_ground = GROUND_RESET;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // --- directed, reset settings: earth gravity, 0.1 s step, 64 points, ground 0
      // at rest on the ground: first point only, the next one drops below
      send_launch(make_launch(0, 0, 0, 0, 0, 0));
      // ordinary arc, lands after about 40 points
      send_launch(make_launch(5 * ONE, 0, -3 * ONE, 2 * ONE, 20 * ONE, -ONE));
      // all-max launch: positions saturate, never lands, hits the point limit
      send_launch(make_launch(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      // all-min launch: below ground from the second point on
      send_launch(make_launch(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      // dropped from the top at full downward speed
      send_launch(make_launch(q16_type'($urandom), Q_MAX, q16_type'($urandom),
                              q16_type'($urandom), Q_MIN, q16_type'($urandom)));
      // barely above ground, no upward speed
      send_launch(make_launch(0, 1, 0, 0, 0, 0));
      wait_for_idle();

      // extreme gravity, huge step, zero point limit (acts as one point)
      configure(Q_MAX, 0, Q_MIN, Q_MIN, 32'h7FFF_FFFF, 0);
      send_launch(random_launch(1'b0));
      send_launch(make_launch(0, 0, 0, 0, 0, 0));
      wait_for_idle();

      // limit above the cap, time saturates from the fourth point, products clamp
      configure(Q_MIN, Q_MAX, Q_MAX, Q_MIN, 32'hFFFF_FFFF, 32'hFFFF_FF7F);
      send_launch(random_launch(1'b0));
      send_launch(make_launch(0, 0, 0, 0, 0, 0));
      send_launch(make_launch(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
      wait_for_idle();

      // zero step: every point sits at the launch; height equal to ground keeps going
      configure(0, 0, 0, 7 * ONE, 0, 5);
      send_launch(make_launch(ONE, 7 * ONE, -ONE, ONE, Q_MAX, ONE));
      send_launch(make_launch(ONE, 7 * ONE - 1, -ONE, ONE, Q_MAX, ONE));
      wait_for_idle();

      // single point, ground at the top; a write to an unmapped address must be ignored
      configure(0, -1, 0, Q_MAX, 1, 1);
      write_reg(UNMAPPED_REG, $urandom);
      send_launch(random_launch(1'b0));
      wait_for_idle();

      // no gravity, one second step: x runs into saturation, y stays on the ground
      configure(0, 0, 0, 0, ONE, 64);
      send_launch(make_launch(0, 0, 0, Q_MAX, 0, Q_MIN));
      send_launch(make_launch(Q_MIN, 0, Q_MAX, Q_MIN, 1, Q_MAX));
      wait_for_idle();

      // --- random phases; phase 2 runs without any idle cycles on either side
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_settings(phase);
         steady = (phase == 2);
         for (item = 0; item < ITEMS_PER_PHASE; item++) begin
            send_launch(random_launch($urandom_range(0, 4) != 0));
         end
         wait_for_idle();
      end

      if (mismatch_count == 0) begin
         $display("tb_projectile_trajectory_sampler_unit OK");
      end else begin
         $display("tb_projectile_trajectory_sampler_unit NOT OK");
      end
      $finish;
   end

endmodule
